/* design/assert_macros.svh */
// assertion helpers used by hold_mode_supervisor.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, held off during reset
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/hms_pkg.sv */
`default_nettype none

package hms_pkg;

   // default sizes
   localparam int TAG_BITS_DEF = 8;
   localparam int SEQ_BITS_DEF = 32;

   // fixed field widths
   localparam int TAG_FIELD_BITS = 8;
   localparam int OUT_SEQ_BITS   = 32;

   // item kinds
   localparam logic FUNC_REQUEST = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // modes
   localparam logic [2:0] MODE_MANUAL   = 3'd0;
   localparam logic [2:0] MODE_HEADING  = 3'd1;
   localparam logic [2:0] MODE_POSHOLD  = 3'd2;
   localparam logic [2:0] MODE_TEST     = 3'd3;
   localparam logic [2:0] MODE_FAILSAFE = 3'd4;

   // transition reasons
   localparam logic [3:0] REASON_STARTUP          = 4'd0;
   localparam logic [3:0] REASON_OVERRIDE_INVALID = 4'd5;
   localparam logic [3:0] REASON_EST_RESET        = 4'd6;
   localparam logic [3:0] REASON_FS_TRIG          = 4'd7;
   localparam logic [3:0] REASON_FS_CLEAR         = 4'd8;

   // reject codes
   localparam logic [3:0] REJ_NONE        = 4'd0;
   localparam logic [3:0] REJ_YAW         = 4'd1;
   localparam logic [3:0] REJ_POS         = 4'd2;
   localparam logic [3:0] REJ_VEL         = 4'd3;
   localparam logic [3:0] REJ_ORIGIN      = 4'd4;
   localparam logic [3:0] REJ_FILTER      = 4'd5;
   localparam logic [3:0] REJ_TEST_UNAUTH = 4'd6;
   localparam logic [3:0] REJ_FS_LATCHED  = 4'd7;
   localparam logic [3:0] REJ_UNSUPPORTED = 4'd8;

   // validity flag bit positions
   localparam int FLAG_YAW    = 0;
   localparam int FLAG_FILTER = 1;
   localparam int FLAG_ORIGIN = 2;
   localparam int FLAG_POS    = 3;
   localparam int FLAG_VEL    = 4;

   // target flag bit positions
   localparam int TGT_HEADING = 0;
   localparam int TGT_POS     = 1;

   typedef struct packed {
      logic               func;
      logic [2:0]         requested_mode;
      logic [3:0]         request_reason;
      logic               test_authorized;
      logic               force_relatch;
      logic [4:0]         valid_flags;
      logic signed [15:0] heading;
      logic signed [31:0] north_pos;
      logic signed [31:0] east_pos;
      logic [7:0]         origin_tag;
      logic [7:0]         reset_count;
      logic [47:0]        timestamp;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               changed;
      logic [3:0]         reject_code;
      logic [2:0]         mode_now;
      logic [2:0]         mode_before;
      logic [3:0]         last_reason;
      logic [31:0]        transition_count;
      logic [31:0]        target_number;
      logic [1:0]         target_flags;
      logic signed [15:0] target_heading;
      logic signed [31:0] target_north;
      logic signed [31:0] target_east;
   } rsp_type;

endpackage

`default_nettype wire

/* design/hold_mode_supervisor.sv */
// an accepted request waits in the input register until the result register is free
// throughput: one request per cycle while rsp_ready keeps the result register free;
// the mode decision between them updates the mode state as the result is registered
// reset: synchronous, active high; mode manual, transition count 1, target cleared
`default_nettype none

`include "assert_macros.svh"

module hold_mode_supervisor #(
   parameter int TAG_BITS = hms_pkg::TAG_BITS_DEF,
   parameter int SEQ_BITS = hms_pkg::SEQ_BITS_DEF
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire hms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output hms_pkg::rsp_type rsp_data
);

   // compared tag width, limited by the field width
   localparam int TAG_W = (TAG_BITS < hms_pkg::TAG_FIELD_BITS) ?
                          TAG_BITS : hms_pkg::TAG_FIELD_BITS;

   // pipeline registers
   logic             in_valid_ff;
   hms_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   hms_pkg::rsp_type out_data_ff;
   logic             advance;

   // supervisor state
   logic [2:0]          mode_ff, mode_in;
   logic [2:0]          prev_mode_ff, prev_mode_in;
   logic [3:0]          reason_ff, reason_in;
   logic [SEQ_BITS-1:0] trans_seq_ff, trans_seq_in;
   logic [47:0]         trans_time_ff, trans_time_in;
   logic [SEQ_BITS-1:0] tgt_seq_ff, tgt_seq_in;
   logic [1:0]          tgt_valid_ff, tgt_valid_in;
   logic signed [15:0]  tgt_heading_ff, tgt_heading_in;
   logic signed [31:0]  tgt_north_ff, tgt_north_in;
   logic signed [31:0]  tgt_east_ff, tgt_east_in;
   logic [TAG_W-1:0]    tgt_origin_ff, tgt_origin_in;
   logic [TAG_W-1:0]    tgt_reset_ff, tgt_reset_in;

   // decision signals
   logic             fs_block;
   logic [3:0]       entry_code;
   logic [3:0]       code;
   logic             acc;
   logic             go;
   logic [2:0]       go_mode;
   logic [3:0]       go_reason;
   logic [TAG_W-1:0] cur_origin;
   logic [TAG_W-1:0] cur_reset;
   logic [4:0]       flags;
   logic             commit;
   hms_pkg::rsp_type rsp_in;

   // handshake: the input stage moves on when the result register is free
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign commit    = in_valid_ff && advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign flags      = in_data_ff.valid_flags;
   assign cur_origin = in_data_ff.origin_tag[TAG_W-1:0];
   assign cur_reset  = in_data_ff.reset_count[TAG_W-1:0];

   // failsafe latch: only a failsafe-cleared request to manual gets out
   assign fs_block = (mode_ff == hms_pkg::MODE_FAILSAFE) &&
                     (in_data_ff.requested_mode != hms_pkg::MODE_FAILSAFE) &&
                     !((in_data_ff.request_reason == hms_pkg::REASON_FS_CLEAR) &&
                       (in_data_ff.requested_mode == hms_pkg::MODE_MANUAL));

   // per-mode entry checks
   always_comb begin
      case (in_data_ff.requested_mode)
         hms_pkg::MODE_MANUAL,
         hms_pkg::MODE_FAILSAFE: begin
            entry_code = hms_pkg::REJ_NONE;
         end
         hms_pkg::MODE_HEADING: begin
            entry_code = flags[hms_pkg::FLAG_YAW] ? hms_pkg::REJ_NONE : hms_pkg::REJ_YAW;
         end
         hms_pkg::MODE_POSHOLD: begin
            if (!flags[hms_pkg::FLAG_FILTER]) begin
               entry_code = hms_pkg::REJ_FILTER;
            end else if (!flags[hms_pkg::FLAG_YAW]) begin
               entry_code = hms_pkg::REJ_YAW;
            end else if (!flags[hms_pkg::FLAG_ORIGIN]) begin
               entry_code = hms_pkg::REJ_ORIGIN;
            end else if (!flags[hms_pkg::FLAG_POS]) begin
               entry_code = hms_pkg::REJ_POS;
            end else if (!flags[hms_pkg::FLAG_VEL]) begin
               entry_code = hms_pkg::REJ_VEL;
            end else begin
               entry_code = hms_pkg::REJ_NONE;
            end
         end
         hms_pkg::MODE_TEST: begin
            entry_code = in_data_ff.test_authorized ? hms_pkg::REJ_NONE
                                                    : hms_pkg::REJ_TEST_UNAUTH;
         end
         default: begin
            entry_code = hms_pkg::REJ_UNSUPPORTED;
         end
      endcase
   end

   // request and tick decision
   always_comb begin
      acc       = 1'b1;
      code      = hms_pkg::REJ_NONE;
      go        = 1'b0;
      go_mode   = in_data_ff.requested_mode;
      go_reason = in_data_ff.request_reason;
      if (in_data_ff.func == hms_pkg::FUNC_REQUEST) begin
         code = fs_block ? hms_pkg::REJ_FS_LATCHED : entry_code;
         if (code != hms_pkg::REJ_NONE) begin
            acc = 1'b0;
         end else if ((in_data_ff.requested_mode != mode_ff) ||
                      (in_data_ff.force_relatch &&
                       (in_data_ff.requested_mode == hms_pkg::MODE_POSHOLD))) begin
            go = 1'b1;
         end
      end else if (mode_ff == hms_pkg::MODE_HEADING) begin
         if (!flags[hms_pkg::FLAG_YAW]) begin
            go        = 1'b1;
            go_mode   = hms_pkg::MODE_FAILSAFE;
            go_reason = hms_pkg::REASON_FS_TRIG;
         end else if (cur_reset != tgt_reset_ff) begin
            go        = 1'b1;
            go_mode   = hms_pkg::MODE_HEADING;
            go_reason = hms_pkg::REASON_EST_RESET;
         end
      end else if (mode_ff == hms_pkg::MODE_POSHOLD) begin
         if (!flags[hms_pkg::FLAG_YAW]) begin
            go        = 1'b1;
            go_mode   = hms_pkg::MODE_FAILSAFE;
            go_reason = hms_pkg::REASON_FS_TRIG;
         end else if ((cur_origin != tgt_origin_ff) || (cur_reset != tgt_reset_ff)) begin
            go        = 1'b1;
            go_mode   = hms_pkg::MODE_HEADING;
            go_reason = hms_pkg::REASON_EST_RESET;
         end else if (!(flags[hms_pkg::FLAG_FILTER] && flags[hms_pkg::FLAG_ORIGIN] &&
                        flags[hms_pkg::FLAG_POS] && flags[hms_pkg::FLAG_VEL])) begin
            go        = 1'b1;
            go_mode   = hms_pkg::MODE_HEADING;
            go_reason = hms_pkg::REASON_OVERRIDE_INVALID;
         end
      end
   end

   // next state on a transition, with a fresh target for hold modes
   always_comb begin
      mode_in        = mode_ff;
      prev_mode_in   = prev_mode_ff;
      reason_in      = reason_ff;
      trans_seq_in   = trans_seq_ff;
      trans_time_in  = trans_time_ff;
      tgt_seq_in     = tgt_seq_ff;
      tgt_valid_in   = tgt_valid_ff;
      tgt_heading_in = tgt_heading_ff;
      tgt_north_in   = tgt_north_ff;
      tgt_east_in    = tgt_east_ff;
      tgt_origin_in  = tgt_origin_ff;
      tgt_reset_in   = tgt_reset_ff;
      if (go) begin
         prev_mode_in   = mode_ff;
         mode_in        = go_mode;
         reason_in      = go_reason;
         trans_seq_in   = trans_seq_ff + {{(SEQ_BITS-1){1'b0}}, 1'b1};
         trans_time_in  = in_data_ff.timestamp;
         tgt_valid_in   = 2'b00;
         tgt_heading_in = '0;
         tgt_north_in   = '0;
         tgt_east_in    = '0;
         tgt_origin_in  = '0;
         tgt_reset_in   = '0;
         if ((go_mode == hms_pkg::MODE_HEADING) || (go_mode == hms_pkg::MODE_POSHOLD)) begin
            tgt_valid_in[hms_pkg::TGT_HEADING] = 1'b1;
            tgt_heading_in = in_data_ff.heading;
            tgt_origin_in  = cur_origin;
            tgt_reset_in   = cur_reset;
            tgt_seq_in     = tgt_seq_ff + {{(SEQ_BITS-1){1'b0}}, 1'b1};
         end
         if (go_mode == hms_pkg::MODE_POSHOLD) begin
            tgt_valid_in[hms_pkg::TGT_POS] = 1'b1;
            tgt_north_in = in_data_ff.north_pos;
            tgt_east_in  = in_data_ff.east_pos;
         end
      end
   end

   // result from the state after this request
   always_comb begin
      rsp_in.accepted         = acc;
      rsp_in.changed          = go;
      rsp_in.reject_code      = code;
      rsp_in.mode_now         = mode_in;
      rsp_in.mode_before      = prev_mode_in;
      rsp_in.last_reason      = reason_in;
      rsp_in.transition_count = hms_pkg::OUT_SEQ_BITS'(trans_seq_in);
      rsp_in.target_number    = hms_pkg::OUT_SEQ_BITS'(tgt_seq_in);
      rsp_in.target_flags     = tgt_valid_in;
      rsp_in.target_heading   = tgt_heading_in;
      rsp_in.target_north     = tgt_north_in;
      rsp_in.target_east      = tgt_east_in;
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (commit) begin
         out_data_ff <= rsp_in;
      end
   end

   // supervisor state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= hms_pkg::MODE_MANUAL;
         prev_mode_ff   <= hms_pkg::MODE_MANUAL;
         reason_ff      <= hms_pkg::REASON_STARTUP;
         trans_seq_ff   <= {{(SEQ_BITS-1){1'b0}}, 1'b1};
         trans_time_ff  <= '0;
         tgt_seq_ff     <= '0;
         tgt_valid_ff   <= 2'b00;
         tgt_heading_ff <= '0;
         tgt_north_ff   <= '0;
         tgt_east_ff    <= '0;
         tgt_origin_ff  <= '0;
         tgt_reset_ff   <= '0;
      end else if (commit) begin
         mode_ff        <= mode_in;
         prev_mode_ff   <= prev_mode_in;
         reason_ff      <= reason_in;
         trans_seq_ff   <= trans_seq_in;
         trans_time_ff  <= trans_time_in;
         tgt_seq_ff     <= tgt_seq_in;
         tgt_valid_ff   <= tgt_valid_in;
         tgt_heading_ff <= tgt_heading_in;
         tgt_north_ff   <= tgt_north_in;
         tgt_east_ff    <= tgt_east_in;
         tgt_origin_ff  <= tgt_origin_in;
         tgt_reset_ff   <= tgt_reset_in;
      end
   end

   // checks
   `ASSERT_CLK_RST(a_poshold_target, clock, reset,
      (mode_ff == hms_pkg::MODE_POSHOLD) |-> (tgt_valid_ff == 2'b11),
      "position hold without a full target")
   `ASSERT_CLK_RST(a_reject_no_change, clock, reset,
      (rsp_valid && !rsp_data.accepted) |->
      (!rsp_data.changed && (rsp_data.reject_code != hms_pkg::REJ_NONE)),
      "rejected request reports a change")
   `ASSERT_CLK_RST(a_transition_time, clock, reset,
      (commit && go) |=> (trans_time_ff == $past(in_data_ff.timestamp)),
      "transition time not taken from the request")
   `ASSERT_CLK(a_mode_range, clock,
      !reset |-> (mode_ff <= hms_pkg::MODE_FAILSAFE),
      "mode out of range")

endmodule

`default_nettype wire
